FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the timing wheel timeout table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/twtt_pkg.sv
// Types and constants shared by the timing wheel timeout table modules.
package twtt_pkg;

    localparam int ID_W    = 32;
    localparam int DELAY_W = 6;
    localparam int KIND_W  = 2;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_ADD     = 2'd1,
        REQ_REFRESH = 2'd2,
        REQ_CANCEL  = 2'd3
    } req_e_t;

    typedef enum logic [KIND_W-1:0] {
        EV_FIRED    = 2'd0,
        EV_RELEASED = 2'd1,
        EV_FULL     = 2'd2
    } ev_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_e_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;    // capture a new request and clear the scan results
        logic rd_en;   // read the table at rd_addr
        logic scan;    // an entry is presented for processing
        logic step;    // the presented entry is committed
        logic finish;  // closing cycle of the request
    } dp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic stall;   // a result has to go out but the output register is full
    } dp_status_t;

endpackage

FILE: hw/rtl/timing_wheel_timeout_table_core.sv
// Top level of the timing wheel timeout table: sequencer plus datapath.
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   s_tvalid/s_tready  tdata: task_id, delay_ticks; tuser: req_type
//  m_*      out  m_tvalid/m_tready  tdata: event_id; tuser: event_kind; tlast: last_event
//
// A request is handled in order: the accept cycle, a walk over every table entry
// in turn through the single read port of the entry memory, and a closing
// cycle in which an add is written or the last result is sent.
// Results leave through a one-deep output register, so the next request is
// accepted while the final result of the previous one still waits.
// A tick holds back its newest expiry so that the final one can carry tlast;
// while m_tready stays low and a second result is due, the walk pauses.
// Reset clears the valid bits at once; no clearing pass is needed.
module timing_wheel_timeout_table_core #(
    parameter int WHEEL_SIZE    = 64,
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] task_id, [37:32] delay_ticks, [39:38] zero
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] event_id
    output logic [1:0]  m_tuser,    // [1:0] event_kind
    output logic        m_tlast     // last_event
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    twtt_pkg::dp_cmd_t    cmd;
    twtt_pkg::dp_status_t status;
    logic [IW-1:0]        proc_idx;
    logic [IW-1:0]        rd_addr;

    // The sequencer owns the walk position; the datapath owns all table state.
    twtt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .proc_idx (proc_idx),
        .rd_addr  (rd_addr)
    );

    // The request fields are captured by the datapath in the accept cycle.
    twtt_dpath #(
        .WHEEL_SIZE    (WHEEL_SIZE),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .proc_idx    (proc_idx),
        .rd_addr     (rd_addr),
        .status      (status),
        .req_type    (s_tuser),
        .task_id     (s_tdata[31:0]),
        .delay_ticks (s_tdata[37:32]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .event_kind  (m_tuser),
        .event_id    (m_tdata),
        .last_event  (m_tlast)
    );

endmodule

FILE: hw/rtl/twtt_ctrl.sv
// Sequencer for the timing wheel timeout table: walks the table once per request.
module twtt_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  twtt_pkg::dp_status_t status,
    output twtt_pkg::dp_cmd_t    cmd,
    output logic [IW-1:0]        proc_idx,
    output logic [IW-1:0]        rd_addr
);

    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    twtt_pkg::state_e_t state_reg, state_next;
    logic [IW-1:0]      proc_idx_reg, proc_idx_next;
    logic               at_last;

    assign at_last  = (proc_idx_reg == LAST_IDX);
    assign proc_idx = proc_idx_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twtt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = twtt_pkg::ST_SCAN;
                end
            end
            twtt_pkg::ST_SCAN:
            begin
                if (!status.stall && at_last)
                begin
                    state_next = twtt_pkg::ST_FINISH;
                end
            end
            twtt_pkg::ST_FINISH:
            begin
                if (!status.stall)
                begin
                    state_next = twtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twtt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        in_ready      = 1'b0;
        rd_addr       = proc_idx_reg + IW'(1);
        proc_idx_next = proc_idx_reg;
        case (state_reg)
            twtt_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load      = in_valid;
                cmd.rd_en     = in_valid;
                rd_addr       = '0;
                proc_idx_next = '0;
            end
            twtt_pkg::ST_SCAN:
            begin
                cmd.scan  = 1'b1;
                cmd.step  = !status.stall;
                cmd.rd_en = !status.stall && !at_last;
                if (!status.stall && !at_last)
                begin
                    proc_idx_next = proc_idx_reg + IW'(1);
                end
            end
            twtt_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= twtt_pkg::ST_IDLE;
            proc_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            proc_idx_reg <= proc_idx_next;
        end
    end

`include "assert_macros.svh"

    `ASSERT_CLK(a_idx_in_table, (state_reg == twtt_pkg::ST_SCAN) |-> (proc_idx_reg <= LAST_IDX), "scan index beyond the table")
    `ASSERT_CLK(a_load_starts_at_zero, cmd.load |=> (proc_idx_reg == '0 && state_reg == twtt_pkg::ST_SCAN), "scan did not start at entry zero")

endmodule

FILE: hw/rtl/twtt_dpath.sv
// Datapath of the timing wheel timeout table: entry memory, valid bits and result registers.
module twtt_dpath #(
    parameter int WHEEL_SIZE    = 64,
    parameter int TABLE_ENTRIES = 16,
    parameter int IW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  twtt_pkg::dp_cmd_t                 cmd,
    input  logic [IW-1:0]                     proc_idx,
    input  logic [IW-1:0]                     rd_addr,
    output twtt_pkg::dp_status_t              status,
    input  logic [1:0]                        req_type,
    input  logic [twtt_pkg::ID_W-1:0]         task_id,
    input  logic [twtt_pkg::DELAY_W-1:0]      delay_ticks,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [twtt_pkg::KIND_W-1:0]       event_kind,
    output logic [twtt_pkg::ID_W-1:0]         event_id,
    output logic                              last_event
);

    localparam int RW     = $clog2(WHEEL_SIZE + 1);
    localparam int NDELAY = 2 ** twtt_pkg::DELAY_W;

    typedef struct packed {
        logic                             act;
        logic [RW-1:0]                    rem;
        logic [twtt_pkg::DELAY_W-1:0]     base;
        logic [twtt_pkg::ID_W-1:0]        id;
    } entry_t;

    // Effective delay: raw delay modulo the wheel size, zero meaning one full turn.
    logic [RW-1:0] eff_lut [NDELAY];
    for (genvar g = 0; g < NDELAY; g++)
    begin : g_eff
        localparam int M = g % WHEEL_SIZE;
        assign eff_lut[g] = (M == 0) ? RW'(WHEEL_SIZE) : RW'(M);
    end

    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    logic                  we;
    logic [IW-1:0]         wa;
    entry_t                wd;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    twtt_pkg::req_e_t               req_type_reg;
    logic [twtt_pkg::ID_W-1:0]      req_id_reg;
    logic [twtt_pkg::DELAY_W-1:0]   req_delay_reg;

    logic                      match_vld_reg, match_vld_next;
    logic [IW-1:0]             match_idx_reg, match_idx_next;
    logic                      free_vld_reg, free_vld_next;
    logic [IW-1:0]             free_idx_reg, free_idx_next;

    logic                           pend_vld_reg, pend_vld_next;
    twtt_pkg::ev_e_t                pend_kind_reg, pend_kind_next;
    logic [twtt_pkg::ID_W-1:0]      pend_id_reg, pend_id_next;

    logic                           out_vld_reg, out_vld_next;
    twtt_pkg::ev_e_t                out_kind_reg, out_kind_next;
    logic [twtt_pkg::ID_W-1:0]      out_id_reg, out_id_next;
    logic                           out_last_reg, out_last_next;

    logic   ev, hit, expire, out_free, scan_emit, fin_emit, emit;
    logic   fin_go;
    logic [twtt_pkg::DELAY_W-1:0] ref_sel;
    logic [RW-1:0]  ref_d;

    assign ev       = valid_reg[proc_idx];
    assign hit      = ev && (rdata_reg.id == req_id_reg);
    assign expire   = (rdata_reg.rem <= RW'(1));
    assign ref_sel  = (req_delay_reg == '0) ? rdata_reg.base : req_delay_reg;
    assign ref_d    = eff_lut[ref_sel];
    assign out_free = !out_vld_reg || m_tready;

    // A second expiry in one tick pushes the held one out; the finish cycle
    // sends the held one (or a full-table reject) marked as the last.
    assign scan_emit = cmd.scan && (req_type_reg == twtt_pkg::REQ_TICK) && ev && expire
                       && pend_vld_reg;
    assign fin_emit  = cmd.finish &&
                       (((req_type_reg == twtt_pkg::REQ_ADD) && !match_vld_reg && !free_vld_reg)
                        || ((req_type_reg != twtt_pkg::REQ_ADD) && pend_vld_reg));
    assign status.stall = (scan_emit || fin_emit) && !out_free;
    assign fin_go       = cmd.finish && !status.stall;

    always_comb
    begin
        we             = 1'b0;
        wa             = proc_idx;
        wd             = rdata_reg;
        valid_next     = valid_reg;
        match_vld_next = match_vld_reg;
        match_idx_next = match_idx_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_kind_next = pend_kind_reg;
        pend_id_next   = pend_id_reg;
        emit           = 1'b0;
        out_kind_next  = pend_kind_reg;
        out_id_next    = pend_id_reg;
        out_last_next  = 1'b0;

        if (cmd.load)
        begin
            match_vld_next = 1'b0;
            free_vld_next  = 1'b0;
            pend_vld_next  = 1'b0;
        end

        if (cmd.step)
        begin
            case (req_type_reg)
                twtt_pkg::REQ_TICK:
                begin
                    if (ev)
                    begin
                        if (expire)
                        begin
                            valid_next[proc_idx] = 1'b0;
                            emit                 = pend_vld_reg;
                            pend_vld_next        = 1'b1;
                            pend_kind_next       = rdata_reg.act ? twtt_pkg::EV_FIRED
                                                                 : twtt_pkg::EV_RELEASED;
                            pend_id_next         = rdata_reg.id;
                        end
                        else
                        begin
                            we     = 1'b1;
                            wd.rem = rdata_reg.rem - RW'(1);
                        end
                    end
                end
                twtt_pkg::REQ_ADD:
                begin
                    if (hit)
                    begin
                        match_vld_next = 1'b1;
                        match_idx_next = proc_idx;
                    end
                    if (!ev && !free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = proc_idx;
                    end
                end
                twtt_pkg::REQ_REFRESH:
                begin
                    if (hit && (ref_d > rdata_reg.rem))
                    begin
                        we     = 1'b1;
                        wd.rem = ref_d;
                    end
                end
                twtt_pkg::REQ_CANCEL:
                begin
                    if (hit)
                    begin
                        we     = 1'b1;
                        wd.act = 1'b0;
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end

        if (fin_go)
        begin
            if (req_type_reg == twtt_pkg::REQ_ADD)
            begin
                wd.act  = 1'b1;
                wd.rem  = eff_lut[req_delay_reg];
                wd.base = req_delay_reg;
                wd.id   = req_id_reg;
                if (match_vld_reg || free_vld_reg)
                begin
                    we             = 1'b1;
                    wa             = match_vld_reg ? match_idx_reg : free_idx_reg;
                    valid_next[wa] = 1'b1;
                end
                else
                begin
                    emit          = 1'b1;
                    out_kind_next = twtt_pkg::EV_FULL;
                    out_id_next   = req_id_reg;
                    out_last_next = 1'b1;
                end
            end
            else if (pend_vld_reg)
            begin
                emit          = 1'b1;
                out_last_next = 1'b1;
                pend_vld_next = 1'b0;
            end
        end

        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            match_vld_reg <= 1'b0;
            free_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            match_vld_reg <= match_vld_next;
            free_vld_reg  <= free_vld_next;
            pend_vld_reg  <= pend_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg  <= twtt_pkg::req_e_t'(req_type);
            req_id_reg    <= task_id;
            req_delay_reg <= delay_ticks;
        end
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        if (emit)
        begin
            out_kind_reg <= out_kind_next;
            out_id_reg   <= out_id_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign event_kind = out_kind_reg;
    assign event_id   = out_id_reg;
    assign last_event = out_last_reg;

`include "assert_macros.svh"

    `ASSERT_NEVER(a_no_overwrite, emit && out_vld_reg && !m_tready, "result register overwritten")
    `ASSERT_NEVER(a_add_holds_nothing, pend_vld_reg && req_type_reg == twtt_pkg::REQ_ADD, "add left an expiry pending")
    `ASSERT_CLK(a_tick_never_allocates, (cmd.step && req_type_reg == twtt_pkg::REQ_TICK) |=> ($countones(valid_reg) <= $past($countones(valid_reg))), "tick allocated an entry")

endmodule

FILE: tb/sv/timing_wheel_timeout_table_core_test.sv
// Self-checking testbench for the timing wheel timeout table core.
module timing_wheel_timeout_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default sizes, and the timer model below
    // mirrors them.
    localparam int WHEEL         = 64;
    localparam int ENTRIES       = 16;
    localparam int RANDOM_TOTAL  = 203;  // random requests after the directed plan
    localparam int ID_POOL       = 24;   // live identifiers the random part reuses
    localparam int HOLDOFF_LEN   = 400;  // receiver hold-off that backs the block up
    localparam int QUIET_LIMIT   = 3000; // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES  = 2 * (ENTRIES + 2) + 8;
    localparam int REPORT_LIMIT  = 10;

    // How a row of the directed plan is checked: against the timer model,
    // against a result typed straight into the row, or for no result at all.
    typedef enum logic [1:0] {
        CHK_PREDICTED,
        CHK_SILENT,
        CHK_SINGLE
    } check_t;

    typedef struct packed {
        twtt_pkg::ev_e_t kind;
        logic [31:0]     id;
        logic            last;
    } timer_event_t;

    typedef struct packed {
        twtt_pkg::req_e_t req;
        logic [31:0]      id;
        logic [5:0]       delay;
        check_t           check;
        twtt_pkg::ev_e_t  kind;
        logic [31:0]      ev_id;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    timing_wheel_timeout_table_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Period of 8 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Private copy of the timer table, kept in step with every accepted request.
    logic        timer_valid [ENTRIES];
    logic [31:0] timer_id    [ENTRIES];
    logic [5:0]  timer_base  [ENTRIES];
    logic [6:0]  timer_left  [ENTRIES];
    logic        timer_armed [ENTRIES];

    timer_event_t step_events[$];    // results of the request just accepted
    timer_event_t pending_events[$]; // results still owed by the block, oldest first

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          holdoff_go = 1'b0;
    int          holdoff_left = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    logic [31:0] id_pool [ID_POOL];

    // Directed plan. Slot numbers in the notes assume the table fills from the
    // lowest free entry upwards.
    stim_row_t plan [27] = '{
        // Tick on an empty table, then refresh and cancel of unknown ids: all silent.
        '{twtt_pkg::REQ_TICK, 32'h0000_0000, 6'd0, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_REFRESH, 32'h5555_AAAA, 6'd5, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_CANCEL, 32'hAAAA_5555, 6'd63, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        // Shortest delay, longest delay and the full turn that delay zero means.
        '{twtt_pkg::REQ_ADD, 32'h0000_0000, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'hFFFF_FFFF, 6'd63, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h1234_5678, 6'd0, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'hA5A5_A5A5, 6'd2, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        // Only the one-tick timer expires, and it alone carries tlast.
        '{twtt_pkg::REQ_TICK, 32'h0000_0000, 6'd0, CHK_SINGLE, twtt_pkg::EV_FIRED,
          32'h0000_0000},
        // Cancel, then a refresh that neither extends it nor re-arms it.
        '{twtt_pkg::REQ_CANCEL, 32'hA5A5_A5A5, 6'd0, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_REFRESH, 32'hA5A5_A5A5, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        // Refresh with delay zero falls back on the stored base (a full turn).
        '{twtt_pkg::REQ_REFRESH, 32'h1234_5678, 6'd0, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        // Adding a live id restarts it in place with a shorter count.
        '{twtt_pkg::REQ_ADD, 32'hFFFF_FFFF, 6'd3, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        // Thirteen more timers fill the table.
        '{twtt_pkg::REQ_ADD, 32'h0000_0101, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0102, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0103, 6'd2, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0104, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0105, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0106, 6'd7, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0107, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0108, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_0109, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_010A, 6'd16, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_010B, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_010C, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        '{twtt_pkg::REQ_ADD, 32'h0000_010D, 6'd1, CHK_SILENT, twtt_pkg::EV_FIRED, 32'h0},
        // A new id on a full table is turned away.
        '{twtt_pkg::REQ_ADD, 32'hDEAD_BEEF, 6'd9, CHK_SINGLE, twtt_pkg::EV_FULL,
          32'hDEAD_BEEF},
        // Many expiries at once, the cancelled timer among them as a release.
        '{twtt_pkg::REQ_TICK, 32'h0000_0000, 6'd0, CHK_PREDICTED, twtt_pkg::EV_FIRED, 32'h0}
    };

    // Delay as the wheel sees it: modulo the wheel size, zero meaning a full turn.
    function automatic logic [6:0] wheel_span(logic [5:0] delay);
        int span;
        span = delay % WHEEL;
        return (span == 0) ? 7'(WHEEL) : 7'(span);
    endfunction

    function automatic int find_timer(logic [31:0] id);
        for (int i = 0; i < ENTRIES; i++)
            if (timer_valid[i] && timer_id[i] == id)
                return i;
        return -1;
    endfunction

    // Applies one request to the timer copy and leaves its results in
    // step_events.
    function automatic void predict_timer_request(twtt_pkg::req_e_t req,
                                                  logic [31:0] id,
                                                  logic [5:0] delay);
        int           slot;
        logic [6:0]   span;
        timer_event_t ev;
        step_events.delete();
        case (req)
            twtt_pkg::REQ_TICK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (timer_valid[i])
                    begin
                        if (timer_left[i] <= 7'd1)
                        begin
                            ev.kind = timer_armed[i] ? twtt_pkg::EV_FIRED
                                                     : twtt_pkg::EV_RELEASED;
                            ev.id = timer_id[i];
                            ev.last = 1'b0;
                            step_events = {step_events, ev};
                            timer_valid[i] = 1'b0;
                            timer_left[i] = 7'd0;
                        end
                        else
                        begin
                            timer_left[i] = timer_left[i] - 7'd1;
                        end
                    end
                end
            end
            twtt_pkg::REQ_ADD:
            begin
                slot = find_timer(id);
                if (slot < 0)
                begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!timer_valid[i])
                            slot = i;
                end
                if (slot < 0)
                begin
                    ev.kind = twtt_pkg::EV_FULL;
                    ev.id = id;
                    ev.last = 1'b0;
                    step_events = {step_events, ev};
                end
                else
                begin
                    timer_valid[slot] = 1'b1;
                    timer_id[slot] = id;
                    timer_base[slot] = delay;
                    timer_left[slot] = wheel_span(delay);
                    timer_armed[slot] = 1'b1;
                end
            end
            twtt_pkg::REQ_REFRESH:
            begin
                slot = find_timer(id);
                if (slot >= 0)
                begin
                    span = wheel_span((delay == 6'd0) ? timer_base[slot] : delay);
                    if (span > timer_left[slot])
                        timer_left[slot] = span;
                end
            end
            default:
            begin
                slot = find_timer(id);
                if (slot >= 0)
                    timer_armed[slot] = 1'b0;
            end
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // Offers one request, waits for it to be taken, and then books the results
    // it is owed. Idle cycles before the request follow send_idle_pct. The
    // request is changed at a falling edge and the handshake is judged at the
    // rising edge.
    task automatic send_request(input twtt_pkg::req_e_t req, input logic [31:0] id,
                                input logic [5:0] delay, input check_t check,
                                input twtt_pkg::ev_e_t kind, input logic [31:0] ev_id);
        timer_event_t typed;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, delay, id};
        s_tuser <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_timer_request(req, id, delay);
        case (check)
            CHK_PREDICTED:
                foreach (step_events[i])
                    pending_events = {pending_events, step_events[i]};
            CHK_SINGLE:
            begin
                typed.kind = kind;
                typed.id = ev_id;
                typed.last = 1'b1;
                pending_events = {pending_events, typed};
            end
            default:
                ;
        endcase
    endtask

    // Builds a random request. Most of them name ids from a small pool so that
    // refreshes, cancels and restarts land on live timers; a few use a fresh
    // id, which mostly makes noise the block ignores.
    task automatic pick_request(input int tick_weight, output twtt_pkg::req_e_t req,
                                output logic [31:0] id, output logic [5:0] delay);
        int roll;
        roll = $urandom_range(99);
        if (roll < tick_weight)
            req = twtt_pkg::REQ_TICK;
        else if (roll < tick_weight + (100 - tick_weight) / 2)
            req = twtt_pkg::REQ_ADD;
        else if ($urandom_range(1) == 0)
            req = twtt_pkg::REQ_REFRESH;
        else
            req = twtt_pkg::REQ_CANCEL;
        id = ($urandom_range(99) < 8) ? $urandom : id_pool[$urandom_range(ID_POOL - 1)];
        delay = 6'($urandom_range(63));
        if (req == twtt_pkg::REQ_ADD && $urandom_range(99) < 75)
            delay = 6'($urandom_range(1, 6));
        else if (req == twtt_pkg::REQ_REFRESH && $urandom_range(99) < 70)
            delay = ($urandom_range(2) == 0) ? 6'd0 : 6'($urandom_range(1, 10));
    endtask

    // Receiver: tready is chosen at each falling edge. A hold-off, once asked
    // for, keeps it low for a long run of cycles counted here.
    always @(negedge clk)
    begin
        if (holdoff_go)
        begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_go = 1'b0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input timer_event_t want,
                                   input timer_event_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected kind %0d id %h last %0d, got kind %0d id %h last %0d",
                     $realtime, what, want.kind, want.id, want.last,
                     got.kind, got.id, got.last);
    endtask

    // Checks each result taken from the block against the oldest one owed.
    always @(posedge clk)
    begin
        timer_event_t got;
        timer_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = twtt_pkg::ev_e_t'(m_tuser);
            got.id = m_tdata;
            got.last = m_tlast;
            if (pending_events.size() == 0)
            begin
                want = '0;
                report_mismatch("result with nothing owed", want, got);
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.kind != want.kind || got.id != want.id || got.last != want.last)
                    report_mismatch("result differs", want, got);
            end
        end
    end

    // Watchdog: gives up once neither side has moved a request for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        twtt_pkg::req_e_t req;
        logic [31:0]      id;
        logic [5:0]       delay;
        int               sent;
        int               tick_weight;

        foreach (timer_valid[i])
        begin
            timer_valid[i] = 1'b0;
            timer_id[i] = '0;
            timer_base[i] = '0;
            timer_left[i] = '0;
            timer_armed[i] = 1'b0;
        end
        foreach (id_pool[i])
            id_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed plan, no idling on either side.
        foreach (plan[r])
            send_request(plan[r].req, plan[r].id, plan[r].delay, plan[r].check,
                         plan[r].kind, plan[r].ev_id);

        // Random part in four idling phases. The first one opens with a long
        // receiver hold-off so that results pile up and the block stops
        // taking requests. Tick density is drawn anew every twenty requests: sparse
        // ticks let the table fill up and turn adds away, dense ticks drain it.
        sent = 0;
        tick_weight = 40;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    holdoff_go = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            while (sent < (phase + 1) * RANDOM_TOTAL / 4)
            begin
                if (sent % 20 == 0)
                    tick_weight = ($urandom_range(1) == 0) ? 40 : 12;
                pick_request(tick_weight, req, id, delay);
                send_request(req, id, delay, CHK_PREDICTED, twtt_pkg::EV_FIRED, 32'h0);
                sent++;
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        // Let every owed result arrive, then watch a little longer for strays.
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/twtt_pkg.sv
hw/rtl/twtt_ctrl.sv
hw/rtl/twtt_dpath.sv
hw/rtl/timing_wheel_timeout_table_core.sv
tb/sv/timing_wheel_timeout_table_core_test.sv
